// ----- rtl/cst_pkg.sv -----
// Shared types and constants for the client slot table with idle timeout.
// Holds the request and result structs, op, status and command codes.
// No dependencies; every other file in rtl/ except cst_ram.sv uses this package.
`default_nettype none

package cst_pkg;

    localparam int SLOTS       = 32;
    localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MAX_RESULTS = 32;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int KEY_W       = 48;
    localparam int TIME_W      = 64;
    localparam int CFG_W       = 32;
    localparam int OP_W        = 3;
    localparam int SEL_W       = 5;
    localparam int OUT_SLOT_W  = 5;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [CFG_W-1:0] IDLE_TIMEOUT_RESET   = 32'd30000;
    localparam logic [CFG_W-1:0] SWEEP_INTERVAL_RESET = 32'd60000;

    localparam logic [0:0] CFG_IDLE_TIMEOUT   = 1'd0;
    localparam logic [0:0] CFG_SWEEP_INTERVAL = 1'd1;

    localparam logic [OP_W-1:0] OP_LOOKUP      = 3'd0;
    localparam logic [OP_W-1:0] OP_ALLOC       = 3'd1;
    localparam logic [OP_W-1:0] OP_SWEEP       = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE     = 3'd3;
    localparam logic [OP_W-1:0] OP_RELEASE_ALL = 3'd4;

    typedef enum logic [2:0] {
        ST_HIT      = 3'd0,
        ST_MISS     = 3'd1,
        ST_ALLOC    = 3'd2,
        ST_FULL     = 3'd3,
        ST_RELEASED = 3'd4,
        ST_EXPIRED  = 3'd5,
        ST_NONE     = 3'd6,
        ST_SKIPPED  = 3'd7
    } status_t;

    typedef enum logic [2:0] {
        CMD_LOOKUP,
        CMD_ALLOC,
        CMD_SWEEP,
        CMD_RELEASE,
        CMD_RELEASE_ALL,
        CMD_NONE
    } cmd_kind_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [KEY_W-1:0]  peer_key;
        logic [SEL_W-1:0]  slot_select;
        logic [TIME_W-1:0] now_ticks;
    } in_t;

    typedef struct packed {
        status_t               status;
        logic [OUT_SLOT_W-1:0] slot_index;
        logic                  last_result;
    } out_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [KEY_W-1:0]  key;
        logic [SLOT_W-1:0] sel;
        logic [TIME_W-1:0] now;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/client_slot_table_with_timeout.sv -----
// Top level of the client slot table with idle timeout: config registers and wiring.
// Instantiates cst_front, cst_cmd_queue and cst_back; uses cst_pkg.
//
// The block keeps 32 peer slots and runs one request at a time in its back end, while
// the front end and a two-entry command queue keep taking requests. Allocate, release,
// a skipped sweep and an out-of-range release complete in the idle state, so these run
// at one request per cycle while the output is free. Lookup and a scanning sweep walk
// the valid slots in ascending order through the key and time RAM read port, issuing a
// read and then comparing for each slot visited; a lookup that hits stops at that slot.
// Release-all visits one valid slot per cycle unless the output stalls. Results come
// one per cycle from an output register while out_ready is high; the last result of a
// request carries last_result. Valid bits clear at reset, so no clearing pass is run.
// Configuration registers (index 0 idle_timeout, 1 sweep_interval) are always writable.
`default_nettype none

module client_slot_table_with_timeout (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    output      logic                      in_ready,
    input  wire cst_pkg::in_t              in_item,
    output      logic                      out_valid,
    input  wire logic                      out_ready,
    output      cst_pkg::out_t             out_item,
    input  wire logic                      cfg_valid,
    output      logic                      cfg_ready,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [cst_pkg::CFG_W-1:0] cfg_data
);

    logic [cst_pkg::CFG_W-1:0] idle_timeout_reg;
    logic [cst_pkg::CFG_W-1:0] sweep_interval_reg;

    logic          push_valid;
    logic          push_ready;
    cst_pkg::cmd_t push_cmd;
    logic          pop_valid;
    logic          pop_ready;
    cst_pkg::cmd_t pop_cmd;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_timeout_reg   <= cst_pkg::IDLE_TIMEOUT_RESET;
            sweep_interval_reg <= cst_pkg::SWEEP_INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                cst_pkg::CFG_IDLE_TIMEOUT:   idle_timeout_reg   <= cfg_data;
                cst_pkg::CFG_SWEEP_INTERVAL: sweep_interval_reg <= cfg_data;
                default:                     idle_timeout_reg   <= idle_timeout_reg;
            endcase
        end
    end

    cst_front u_front (
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    cst_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    cst_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_cmd        (pop_cmd),
        .idle_timeout   (idle_timeout_reg),
        .sweep_interval (sweep_interval_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_item       (out_item)
    );

endmodule

`default_nettype wire

// ----- rtl/cst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Used for the slot key and last-seen stores; no dependencies.
`default_nettype none

module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                             clk,
    input  wire logic                             we,
    input  wire logic [$clog2(DEPTH)-1:0]         waddr,
    input  wire logic [WIDTH-1:0]                 wdata,
    input  wire logic [$clog2(DEPTH)-1:0]         raddr,
    output      logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/cst_front.sv -----
// Front end: accepts requests and classifies them into back-end commands.
// Drops unknown ops and flags out-of-range releases. Uses cst_pkg.
`default_nettype none

module cst_front (
    input  wire logic         in_valid,
    output      logic         in_ready,
    input  wire cst_pkg::in_t in_item,
    output      logic         push_valid,
    input  wire logic         push_ready,
    output      cst_pkg::cmd_t push_cmd
);

    localparam int SW = cst_pkg::SLOT_W;

    logic known;

    always_comb
    begin
        known         = 1'b1;
        push_cmd.kind = cst_pkg::CMD_NONE;
        push_cmd.key  = in_item.peer_key;
        push_cmd.sel  = SW'(in_item.slot_select);
        push_cmd.now  = in_item.now_ticks;
        unique case (in_item.op)
            cst_pkg::OP_LOOKUP:      push_cmd.kind = cst_pkg::CMD_LOOKUP;
            cst_pkg::OP_ALLOC:       push_cmd.kind = cst_pkg::CMD_ALLOC;
            cst_pkg::OP_SWEEP:       push_cmd.kind = cst_pkg::CMD_SWEEP;
            cst_pkg::OP_RELEASE:
            begin
                if (int'(in_item.slot_select) >= cst_pkg::SLOTS)
                begin
                    push_cmd.kind = cst_pkg::CMD_NONE;
                end
                else
                begin
                    push_cmd.kind = cst_pkg::CMD_RELEASE;
                end
            end
            cst_pkg::OP_RELEASE_ALL: push_cmd.kind = cst_pkg::CMD_RELEASE_ALL;
            default:                 known = 1'b0;
        endcase
    end

    assign in_ready   = push_ready;
    assign push_valid = in_valid && known;

endmodule

`default_nettype wire

// ----- rtl/cst_cmd_queue.sv -----
// Short command queue between front end and back end.
// Lets either side stall on its own. Uses cst_pkg.
`default_nettype none

module cst_cmd_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push_valid,
    output      logic          push_ready,
    input  wire cst_pkg::cmd_t push_cmd,
    output      logic          pop_valid,
    input  wire logic          pop_ready,
    output      cst_pkg::cmd_t pop_cmd
);

    localparam int PW = cst_pkg::QPTR_W;
    localparam int CW = cst_pkg::QCNT_W;

    cst_pkg::cmd_t    mem_reg [cst_pkg::QDEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CW'(cst_pkg::QDEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(cst_pkg::QDEPTH - 1)) ? '0
                                                                      : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(cst_pkg::QDEPTH - 1)) ? '0
                                                                      : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/cst_back.sv -----
// Back end: executes commands against the slot table and drives the result register.
// Holds valid bits in flops, keys and last-seen times in cst_ram. Uses cst_pkg, cst_ram.
`default_nettype none

module cst_back (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       pop_valid,
    output      logic                       pop_ready,
    input  wire cst_pkg::cmd_t              pop_cmd,
    input  wire logic [cst_pkg::CFG_W-1:0]  idle_timeout,
    input  wire logic [cst_pkg::CFG_W-1:0]  sweep_interval,
    output      logic                       out_valid,
    input  wire logic                       out_ready,
    output      cst_pkg::out_t              out_item
);

    localparam int SW = cst_pkg::SLOT_W;
    localparam int CW = cst_pkg::CNT_W;
    localparam int TW = cst_pkg::TIME_W;
    localparam int KW = cst_pkg::KEY_W;
    localparam int OW = cst_pkg::OUT_SLOT_W;
    localparam int N  = cst_pkg::SLOTS;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ISSUE,
        S_CMP
    } state_t;

    state_t            state_reg,      state_next;
    cst_pkg::cmd_t     cmd_reg,        cmd_next;
    logic [N-1:0]      valid_reg,      valid_next;
    logic [TW-1:0]     prev_sweep_reg, prev_sweep_next;
    logic [N-1:0]      pend_reg,       pend_next;
    logic [SW-1:0]     rd_idx_reg,     rd_idx_next;
    logic              held_valid_reg, held_valid_next;
    logic [SW-1:0]     held_idx_reg,   held_idx_next;
    logic [CW-1:0]     cnt_reg,        cnt_next;
    logic              out_valid_reg,  out_valid_next;
    cst_pkg::out_t     out_reg,        out_next;

    logic [SW-1:0]     pend_idx;
    logic              pend_any;
    logic [SW-1:0]     free_idx;
    logic              free_any;
    logic              out_free;
    logic              alloc_we;
    logic [SW-1:0]     rd_addr;
    logic [KW-1:0]     key_rd;
    logic [TW-1:0]     time_rd;
    cst_pkg::status_t  held_status;

    function automatic cst_pkg::out_t mk_out(cst_pkg::status_t st, logic [SW-1:0] idx,
                                             logic last);
        cst_pkg::out_t r;
        r.status      = st;
        r.slot_index  = OW'(idx);
        r.last_result = last;
        return r;
    endfunction

    always_comb
    begin
        pend_idx = '0;
        pend_any = 1'b0;
        free_idx = '0;
        free_any = 1'b0;
        for (int i = N - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
            begin
                pend_idx = SW'(i);
                pend_any = 1'b1;
            end
            if (!valid_reg[i])
            begin
                free_idx = SW'(i);
                free_any = 1'b1;
            end
        end
    end

    assign out_free    = !out_valid_reg || out_ready;
    assign rd_addr     = (state_reg == S_ISSUE) ? pend_idx : rd_idx_reg;
    assign held_status = (cmd_reg.kind == cst_pkg::CMD_SWEEP) ? cst_pkg::ST_EXPIRED
                                                               : cst_pkg::ST_RELEASED;

    cst_ram #(.WIDTH(KW), .DEPTH(N)) u_key_ram (
        .clk   (clk),
        .we    (alloc_we),
        .waddr (free_idx),
        .wdata (pop_cmd.key),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    cst_ram #(.WIDTH(TW), .DEPTH(N)) u_time_ram (
        .clk   (clk),
        .we    (alloc_we),
        .waddr (free_idx),
        .wdata (pop_cmd.now),
        .raddr (rd_addr),
        .rdata (time_rd)
    );

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        valid_next      = valid_reg;
        prev_sweep_next = prev_sweep_reg;
        pend_next       = pend_reg;
        rd_idx_next     = rd_idx_reg;
        held_valid_next = held_valid_reg;
        held_idx_next   = held_idx_reg;
        cnt_next        = cnt_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        pop_ready       = 1'b0;
        alloc_we        = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (pop_valid && out_free)
                begin
                    pop_ready       = 1'b1;
                    cmd_next        = pop_cmd;
                    cnt_next        = '0;
                    held_valid_next = 1'b0;
                    unique case (pop_cmd.kind)
                        cst_pkg::CMD_LOOKUP:
                        begin
                            pend_next  = valid_reg;
                            state_next = S_ISSUE;
                        end
                        cst_pkg::CMD_ALLOC:
                        begin
                            out_valid_next = 1'b1;
                            if (free_any)
                            begin
                                valid_next[free_idx] = 1'b1;
                                alloc_we             = 1'b1;
                                out_next = mk_out(cst_pkg::ST_ALLOC, free_idx, 1'b1);
                            end
                            else
                            begin
                                out_next = mk_out(cst_pkg::ST_FULL, '0, 1'b1);
                            end
                        end
                        cst_pkg::CMD_SWEEP:
                        begin
                            if (pop_cmd.now - prev_sweep_reg < TW'(sweep_interval))
                            begin
                                out_valid_next = 1'b1;
                                out_next = mk_out(cst_pkg::ST_SKIPPED, '0, 1'b1);
                            end
                            else
                            begin
                                prev_sweep_next = pop_cmd.now;
                                pend_next       = valid_reg;
                                state_next      = S_ISSUE;
                            end
                        end
                        cst_pkg::CMD_RELEASE:
                        begin
                            valid_next[pop_cmd.sel] = 1'b0;
                            out_valid_next          = 1'b1;
                            out_next = mk_out(cst_pkg::ST_RELEASED, pop_cmd.sel, 1'b1);
                        end
                        cst_pkg::CMD_RELEASE_ALL:
                        begin
                            pend_next  = valid_reg;
                            state_next = S_ISSUE;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = mk_out(cst_pkg::ST_NONE, '0, 1'b1);
                        end
                    endcase
                end
            end
            S_ISSUE:
            begin
                if (!pend_any || cnt_reg == CW'(cst_pkg::MAX_RESULTS))
                begin
                    if (out_free)
                    begin
                        out_valid_next  = 1'b1;
                        state_next      = S_IDLE;
                        held_valid_next = 1'b0;
                        if (cmd_reg.kind == cst_pkg::CMD_LOOKUP)
                        begin
                            out_next = mk_out(cst_pkg::ST_MISS, '0, 1'b1);
                        end
                        else if (held_valid_reg)
                        begin
                            out_next = mk_out(held_status, held_idx_reg, 1'b1);
                        end
                        else
                        begin
                            out_next = mk_out(cst_pkg::ST_NONE, '0, 1'b1);
                        end
                    end
                end
                else if (cmd_reg.kind == cst_pkg::CMD_RELEASE_ALL)
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next = mk_out(cst_pkg::ST_RELEASED, held_idx_reg, 1'b0);
                        end
                        valid_next[pend_idx] = 1'b0;
                        pend_next[pend_idx]  = 1'b0;
                        held_valid_next      = 1'b1;
                        held_idx_next        = pend_idx;
                        cnt_next             = cnt_reg + CW'(1);
                    end
                end
                else
                begin
                    pend_next[pend_idx] = 1'b0;
                    rd_idx_next         = pend_idx;
                    state_next          = S_CMP;
                end
            end
            S_CMP:
            begin
                if (cmd_reg.kind == cst_pkg::CMD_LOOKUP)
                begin
                    if (key_rd == cmd_reg.key)
                    begin
                        if (out_free)
                        begin
                            out_valid_next = 1'b1;
                            out_next       = mk_out(cst_pkg::ST_HIT, rd_idx_reg, 1'b1);
                            state_next     = S_IDLE;
                        end
                    end
                    else
                    begin
                        state_next = S_ISSUE;
                    end
                end
                else if (cmd_reg.now - time_rd >= TW'(idle_timeout))
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_next = mk_out(cst_pkg::ST_EXPIRED, held_idx_reg, 1'b0);
                        end
                        valid_next[rd_idx_reg] = 1'b0;
                        held_valid_next        = 1'b1;
                        held_idx_next          = rd_idx_reg;
                        cnt_next               = cnt_reg + CW'(1);
                        state_next             = S_ISSUE;
                    end
                end
                else
                begin
                    state_next = S_ISSUE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cmd_reg        <= '0;
            valid_reg      <= '0;
            prev_sweep_reg <= '0;
            pend_reg       <= '0;
            rd_idx_reg     <= '0;
            held_valid_reg <= 1'b0;
            held_idx_reg   <= '0;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            valid_reg      <= valid_next;
            prev_sweep_reg <= prev_sweep_next;
            pend_reg       <= pend_next;
            rd_idx_reg     <= rd_idx_next;
            held_valid_reg <= held_valid_next;
            held_idx_reg   <= held_idx_next;
            cnt_reg        <= cnt_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;

`ifndef SYNTHESIS
    a_idle_no_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !held_valid_reg)
        else $error("held result survived into idle");

    a_held_freed: assert property (@(posedge clk) disable iff (!rst_n)
        held_valid_reg |-> !valid_reg[held_idx_reg])
        else $error("held slot still marked valid");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(cst_pkg::MAX_RESULTS))
        else $error("result count past limit");

    a_cmp_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CMP |-> $past(state_reg) == S_ISSUE || $past(state_reg) == S_CMP)
        else $error("compare without a read issued");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == cst_pkg::ST_HIT
                          || out_reg.status == cst_pkg::ST_MISS
                          || out_reg.status == cst_pkg::ST_ALLOC
                          || out_reg.status == cst_pkg::ST_FULL
                          || out_reg.status == cst_pkg::ST_SKIPPED)
        |-> out_reg.last_result)
        else $error("single-result status without last mark");
`endif

endmodule

`default_nettype wire

// ----- tb/cst_table_checker.sv -----
// Checker for the client slot table: follows every accepted request and config write,
// keeps its own copy of the slot table and compares each accepted result with it.
// Depends on cst_pkg; instantiated beside the block by tb_client_slot_table_with_timeout.
module cst_table_checker (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      in_valid,
    input  wire logic                      in_ready,
    input  wire cst_pkg::in_t              in_item,
    input  wire logic                      out_valid,
    input  wire logic                      out_ready,
    input  wire cst_pkg::out_t             out_item,
    input  wire logic                      cfg_valid,
    input  wire logic                      cfg_ready,
    input  wire logic [0:0]                cfg_index,
    input  wire logic [cst_pkg::CFG_W-1:0] cfg_data,
    output int                             mismatches,
    output int                             results_due
);
    import cst_pkg::*;

    logic [CFG_W-1:0]  idle_limit;
    logic [CFG_W-1:0]  sweep_gap;
    logic              slot_busy [SLOTS];
    logic [KEY_W-1:0]  slot_peer [SLOTS];
    logic [TIME_W-1:0] slot_seen [SLOTS];
    logic [TIME_W-1:0] last_scan;
    out_t              pending_results [$];

    task automatic push_result(input status_t st, input int slot);
        out_t r;
        r.status      = st;
        r.slot_index  = OUT_SLOT_W'(slot);
        r.last_result = 1'b0;
        pending_results.push_back(r);
    endtask

    task automatic close_request(input int count);
        out_t r;
        if (count == 0)
            push_result(ST_NONE, 0);
        r = pending_results.pop_back();
        r.last_result = 1'b1;
        pending_results.push_back(r);
    endtask

    task automatic apply_to_table(input in_t req);
        int                i;
        int                found;
        int                freed;
        logic [TIME_W-1:0] age;
        found = -1;
        freed = 0;
        case (req.op)
            OP_LOOKUP: begin
                for (i = 0; i < SLOTS; i++)
                    if (found < 0 && slot_busy[i] && slot_peer[i] == req.peer_key)
                        found = i;
                if (found >= 0)
                    push_result(ST_HIT, found);
                else
                    push_result(ST_MISS, 0);
                close_request(1);
            end
            OP_ALLOC: begin
                for (i = 0; i < SLOTS; i++)
                    if (found < 0 && !slot_busy[i])
                        found = i;
                if (found >= 0) begin
                    slot_busy[found] = 1'b1;
                    slot_peer[found] = req.peer_key;
                    slot_seen[found] = req.now_ticks;
                    push_result(ST_ALLOC, found);
                end
                else
                    push_result(ST_FULL, 0);
                close_request(1);
            end
            OP_SWEEP: begin
                age = req.now_ticks - last_scan;
                if (age < TIME_W'(sweep_gap)) begin
                    push_result(ST_SKIPPED, 0);
                    close_request(1);
                end
                else begin
                    last_scan = req.now_ticks;
                    for (i = 0; i < SLOTS && freed < MAX_RESULTS; i++) begin
                        age = req.now_ticks - slot_seen[i];
                        if (slot_busy[i] && age >= TIME_W'(idle_limit)) begin
                            slot_busy[i] = 1'b0;
                            push_result(ST_EXPIRED, i);
                            freed++;
                        end
                    end
                    close_request(freed);
                end
            end
            OP_RELEASE: begin
                if (int'(req.slot_select) >= SLOTS)
                    push_result(ST_NONE, 0);
                else begin
                    slot_busy[req.slot_select] = 1'b0;
                    push_result(ST_RELEASED, int'(req.slot_select));
                end
                close_request(1);
            end
            OP_RELEASE_ALL: begin
                for (i = 0; i < SLOTS && freed < MAX_RESULTS; i++) begin
                    if (slot_busy[i]) begin
                        slot_busy[i] = 1'b0;
                        push_result(ST_RELEASED, i);
                        freed++;
                    end
                end
                close_request(freed);
            end
            default: ;
        endcase
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (pending_results.size() == 0) begin
            $error("unexpected result: status %0d slot_index %0d last_result %0d",
                   got.status, got.slot_index, got.last_result);
            mismatches++;
        end
        else begin
            want = pending_results.pop_front();
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                mismatches++;
            end
            if (got.slot_index !== want.slot_index) begin
                $error("slot_index: expected %0d, got %0d", want.slot_index, got.slot_index);
                mismatches++;
            end
            if (got.last_result !== want.last_result) begin
                $error("last_result: expected %0d, got %0d", want.last_result,
                       got.last_result);
                mismatches++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            idle_limit = IDLE_TIMEOUT_RESET;
            sweep_gap  = SWEEP_INTERVAL_RESET;
            last_scan  = '0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_busy[i] = 1'b0;
                slot_peer[i] = '0;
                slot_seen[i] = '0;
            end
            pending_results.delete();
            mismatches = 0;
        end
        else begin
            if (out_valid && out_ready)
                check_result(out_item);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_IDLE_TIMEOUT:   idle_limit = cfg_data;
                    CFG_SWEEP_INTERVAL: sweep_gap  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                apply_to_table(in_item);
        end
        results_due = pending_results.size();
    end

endmodule

// ----- tb/tb_client_slot_table_with_timeout.sv -----
// Testbench top for the client slot table: drives requests, config writes and result
// back-pressure, and reports the verdict from the failure count of cst_table_checker.
// Depends on cst_pkg, client_slot_table_with_timeout and cst_table_checker.
module tb_client_slot_table_with_timeout;
    import cst_pkg::*;

    localparam logic [OP_W-1:0] OP_RESERVED_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = 3'd7;
    localparam int              DRAIN_CYCLES   = 2 * SLOTS + 16;
    localparam int              HOLD_CYCLES    = 300;
    localparam int              POOL_DEPTH     = 16;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    in_t               in_item = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    out_t              out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [0:0]        cfg_index = '0;
    logic [CFG_W-1:0]  cfg_data = '0;
    int                mismatches;
    int                results_due;

    logic [TIME_W-1:0] ticks;
    logic [KEY_W-1:0]  key_pool [$];
    bit                in_gaps;
    bit                out_gaps;
    int                long_hold;

    client_slot_table_with_timeout i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    cst_table_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_item     (in_item),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_item    (out_item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("status: fail");
        $finish;
    end

    function automatic logic [KEY_W-1:0] rand_key();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        return raw[KEY_W-1:0];
    endfunction

    function automatic logic [KEY_W-1:0] pool_key();
        if (key_pool.size() == 0)
            return rand_key();
        return key_pool[$urandom_range(0, key_pool.size() - 1)];
    endfunction

    function automatic logic [TIME_W-1:0] rand_ticks();
        return {$urandom, $urandom};
    endfunction

    task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [SEL_W-1:0] sel, input logic [TIME_W-1:0] now);
        int gap;
        gap = in_gaps ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item.op          = op;
        in_item.peer_key    = key;
        in_item.slot_select = sel;
        in_item.now_ticks   = now;
        in_valid            = 1'b1;
        do @(posedge clk); while (!in_ready);
        @(negedge clk);
    endtask

    task automatic settle();
        in_valid = 1'b0;
        while (results_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [CFG_W-1:0] value);
        settle();
        cfg_index = idx;
        cfg_data  = value;
        cfg_valid = 1'b1;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic alloc_peer();
        logic [KEY_W-1:0] key;
        if (key_pool.size() > 0 && $urandom_range(0, 4) == 0)
            key = pool_key();
        else begin
            key = rand_key();
            key_pool.push_back(key);
            if (key_pool.size() > POOL_DEPTH)
                void'(key_pool.pop_front());
        end
        issue(OP_ALLOC, key, SEL_W'($urandom), ticks);
    endtask

    task automatic fill_table();
        issue(OP_RELEASE_ALL, rand_key(), SEL_W'($urandom), rand_ticks());
        repeat (SLOTS + 2) begin
            ticks += $urandom_range(0, 50);
            alloc_peer();
        end
    endtask

    task automatic random_run(input int count, input int step_max);
        int pick;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            ticks += $urandom_range(0, step_max);
            if ($urandom_range(0, 49) == 0)
                ticks = rand_ticks();
            if (pick < 30)
                alloc_peer();
            else if (pick < 60)
                issue(OP_LOOKUP, ($urandom_range(0, 9) < 7) ? pool_key() : rand_key(),
                      SEL_W'($urandom), rand_ticks());
            else if (pick < 75)
                issue(OP_SWEEP, rand_key(), SEL_W'($urandom), ticks);
            else if (pick < 88)
                issue(OP_RELEASE, rand_key(), SEL_W'($urandom), rand_ticks());
            else if (pick < 93)
                issue(OP_RELEASE_ALL, rand_key(), SEL_W'($urandom), rand_ticks());
            else
                issue(OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI)), rand_key(),
                      SEL_W'($urandom), rand_ticks());
        end
    endtask

    // receiver: per-result stall, plus one long hold on request
    initial begin
        int stall;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (long_hold > 0) begin
                out_ready = 1'b0;
                repeat (long_hold) @(negedge clk);
                long_hold = 0;
            end
            stall = out_gaps ? $urandom_range(0, 9) : 0;
            if (stall > 0) begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin
        logic [KEY_W-1:0] peer_a;
        logic [KEY_W-1:0] peer_b;
        peer_a    = 48'h0A00_0001_1F90;
        peer_b    = 48'hC0A8_0102_0035;
        long_hold = 0;
        in_gaps   = 1'b1;
        out_gaps  = 1'b1;
        ticks     = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        issue(OP_LOOKUP, '0, '0, '0);
        issue(OP_ALLOC, '1, '1, '0);
        issue(OP_ALLOC, '0, '0, '1);
        issue(OP_LOOKUP, '1, '0, '1);
        issue(OP_LOOKUP, '0, '1, '0);
        issue(OP_SWEEP, '0, '0, 64'd100);
        issue(OP_RELEASE, '0, '0, '0);
        issue(OP_RELEASE, '1, '0, '1);
        issue(OP_RELEASE, '0, '1, '0);
        issue(OP_RELEASE_ALL, '1, '1, '1);
        issue(OP_RELEASE_ALL, '0, '0, '0);
        issue(OP_RESERVED_LO, '1, '1, '1);
        issue(OP_RESERVED_LO + 3'd1, '0, '0, '0);
        issue(OP_RESERVED_HI, '1, '1, '1);
        issue(OP_ALLOC, peer_a, '0, 64'd1000);
        issue(OP_ALLOC, peer_a, '0, 64'd1000);
        issue(OP_LOOKUP, peer_a, '0, '0);
        issue(OP_SWEEP, '0, '0, 64'd59999);
        issue(OP_SWEEP, '0, '0, 64'd60000);
        issue(OP_SWEEP, '0, '0, 64'd60001);
        issue(OP_ALLOC, peer_b, '0, '1);
        issue(OP_SWEEP, '0, '0, '0);
        issue(OP_LOOKUP, peer_b, '0, '0);
        issue(OP_RELEASE_ALL, '0, '0, '0);

        write_reg(CFG_IDLE_TIMEOUT, '0);
        write_reg(CFG_SWEEP_INTERVAL, '0);
        ticks = 64'd5000;
        fill_table();
        issue(OP_SWEEP, rand_key(), SEL_W'($urandom), ticks);
        in_gaps  = 1'b0;
        out_gaps = 1'b0;
        random_run(60, 200);

        write_reg(CFG_IDLE_TIMEOUT, '1);
        write_reg(CFG_SWEEP_INTERVAL, '1);
        in_gaps  = 1'b1;
        out_gaps = 1'b1;
        ticks    = 64'hFFFF_FFFF_FFFF_F000;
        random_run(60, 4000);

        write_reg(CFG_IDLE_TIMEOUT, CFG_W'($urandom_range(50, 2000)));
        write_reg(CFG_SWEEP_INTERVAL, CFG_W'($urandom_range(0, 500)));
        out_gaps = 1'b0;
        random_run(70, 300);

        // hold results back so the block fills and stalls its input
        in_gaps   = 1'b0;
        long_hold = HOLD_CYCLES;
        fill_table();
        repeat (6)
            issue(OP_LOOKUP, pool_key(), SEL_W'($urandom), rand_ticks());
        issue(OP_RELEASE_ALL, rand_key(), SEL_W'($urandom), rand_ticks());

        write_reg(CFG_IDLE_TIMEOUT, CFG_W'($urandom));
        write_reg(CFG_SWEEP_INTERVAL, CFG_W'($urandom_range(0, 1000)));
        out_gaps = 1'b1;
        random_run(50, 1000);

        settle();
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
